// ===== sv/tpwp_pkg.sv =====
// Shared types, band tables and byte packing for the tuner PLL word programmer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tpwp_pkg;

    // Standard table
    localparam int NUM_STANDARDS = 8;
    localparam int STD_ROWS      = 8;
    localparam int STD_LIMIT     = (NUM_STANDARDS < STD_ROWS) ? NUM_STANDARDS : STD_ROWS;

    // Widths
    localparam int RF_W   = 30;        // rf_frequency_hz
    localparam int SI_W   = 3;         // standard_index
    localparam int F_W    = 31;        // LO frequency in Hz
    localparam int ROW_W  = 5;         // band row index
    localparam int N_W    = 12;        // divider bits kept
    localparam int X_W    = 36;        // LO << spd plus rounding half
    localparam int Y_W    = 32;        // X >> 4
    localparam int IDX_W  = 4;         // byte_index
    localparam int BYTE_W = 8;

    // Band tables
    localparam int ORIG_ROWS = 28;
    localparam int A_ROWS    = 25;
    localparam int MHZ       = 1000000;

    // round(v / 250000) = floor((v + 125000) / 16 / 15625); the last step is a
    // reciprocal multiply, exact for any 32-bit numerator.
    localparam int            ROUND_HALF  = 125000;
    localparam int            PRE_SHIFT   = 4;
    localparam int            RECIP_SHIFT = 44;
    localparam logic [30:0]   RECIP       = 31'd1125899907;   // ceil(2^44 / 15625)
    localparam int            PROD_W      = Y_W + 31;

    // Mode register codes
    localparam logic [1:0] TM_ORIG   = 2'd0;
    localparam logic [1:0] TM_ANALOG = 2'd1;
    localparam logic [1:0] TM_DVBT   = 2'd2;

    // Last byte positions
    localparam logic [IDX_W-1:0] LAST_ORIG = 4'd6;
    localparam logic [IDX_W-1:0] LAST_A    = 4'd12;

    typedef enum logic [1:0] {
        MODE_ORIG,
        MODE_ANALOG,
        MODE_DVBT
    } tpwp_mode_t;

    // One classified request, passed from front to back
    typedef struct packed {
        logic [F_W-1:0]   f_lo;
        tpwp_mode_t       mode;
        logic [ROW_W-1:0] row;
        logic             lpf;
    } tpwp_job_t;

    // Band row fields; A-variant rows leave bp and d15 at zero
    typedef struct packed {
        logic [2:0] spd;
        logic [1:0] svco;
        logic [2:0] sbs;
        logic [2:0] bp;
        logic [1:0] gc3;
        logic       d15;
    } tpwp_band_t;

    localparam logic [22:0] STD_IF_HZ [STD_ROWS] = '{
        23'd5750000, 23'd6750000, 23'd7750000, 23'd7750000,
        23'd7750000, 23'd7750000, 23'd1250000, 23'd4750000
    };
    localparam logic STD_LPF [STD_ROWS] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // Original chip
    localparam logic [9:0] ORIG_LO [ORIG_ROWS] = '{
        10'd62,  10'd66,  10'd76,  10'd84,  10'd93,  10'd98,  10'd109, 10'd123,
        10'd133, 10'd151, 10'd154, 10'd181, 10'd185, 10'd217, 10'd244, 10'd265,
        10'd302, 10'd324, 10'd370, 10'd454, 10'd493, 10'd530, 10'd554, 10'd604,
        10'd696, 10'd740, 10'd820, 10'd865
    };
    localparam logic [1:0] ORIG_SPD [ORIG_ROWS] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };
    localparam logic [1:0] ORIG_BS [ORIG_ROWS] = '{
        2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3,
        2'd2, 2'd3, 2'd1, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
    };
    localparam logic [2:0] ORIG_BP [ORIG_ROWS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };
    localparam logic [1:0] ORIG_GC3 [ORIG_ROWS] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };
    localparam logic ORIG_D15 [ORIG_ROWS] = '{
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };

    // A-variant, analog TV
    localparam logic [9:0] AV_LO [A_ROWS] = '{
        10'd56,  10'd67,  10'd81,  10'd97,  10'd113, 10'd134, 10'd154, 10'd162, 10'd183,
        10'd195, 10'd227, 10'd269, 10'd325, 10'd390, 10'd455, 10'd520, 10'd538, 10'd554,
        10'd620, 10'd650, 10'd700, 10'd780, 10'd820, 10'd870, 10'd911
    };
    localparam logic [1:0] AV_SVCO [A_ROWS] = '{
        2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1,
        2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3
    };
    localparam logic [2:0] AV_SPD [A_ROWS] = '{
        3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam logic [2:0] AV_SBS [A_ROWS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };
    localparam logic [1:0] AV_GC3 [A_ROWS] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd3, 2'd3, 2'd1,
        2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };

    // A-variant, DVB-T
    localparam logic [9:0] DV_LO [A_ROWS] = '{
        10'd57,  10'd67,  10'd81,  10'd98,  10'd114, 10'd135, 10'd154, 10'd163, 10'd183,
        10'd195, 10'd228, 10'd269, 10'd290, 10'd325, 10'd390, 10'd455, 10'd520, 10'd538,
        10'd550, 10'd620, 10'd650, 10'd700, 10'd780, 10'd820, 10'd870
    };
    localparam logic [1:0] DV_SVCO [A_ROWS] = '{
        2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1,
        2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3
    };
    localparam logic [2:0] DV_SPD [A_ROWS] = '{
        3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };
    localparam logic [2:0] DV_SBS [A_ROWS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };
    localparam logic [1:0] DV_GC3 [A_ROWS] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
    };

    // First row whose upper limit is not exceeded, last row otherwise.
    // Compares are against constants and run in parallel.
    function automatic logic [ROW_W-1:0] tpwp_find_row(input tpwp_mode_t mode,
                                                       input logic [F_W-1:0] f);
        logic [ROW_W-1:0] idx_orig;
        logic [ROW_W-1:0] idx_av;
        logic [ROW_W-1:0] idx_dv;
        logic [ROW_W-1:0] idx;
        idx_orig = ROW_W'(ORIG_ROWS - 1);
        for (int r = ORIG_ROWS - 2; r >= 0; r--)
        begin
            if (f <= F_W'(ORIG_LO[r]) * F_W'(MHZ))
                idx_orig = ROW_W'(r);
        end
        idx_av = ROW_W'(A_ROWS - 1);
        idx_dv = ROW_W'(A_ROWS - 1);
        for (int r = A_ROWS - 2; r >= 0; r--)
        begin
            if (f <= F_W'(AV_LO[r]) * F_W'(MHZ))
                idx_av = ROW_W'(r);
            if (f <= F_W'(DV_LO[r]) * F_W'(MHZ))
                idx_dv = ROW_W'(r);
        end
        case (mode)
            MODE_ANALOG: idx = idx_av;
            MODE_DVBT:   idx = idx_dv;
            default:     idx = idx_orig;
        endcase
        return idx;
    endfunction

    function automatic tpwp_band_t tpwp_band(input tpwp_mode_t mode,
                                             input logic [ROW_W-1:0] row);
        tpwp_band_t b;
        b = '0;
        case (mode)
            MODE_ANALOG:
            begin
                b.spd  = AV_SPD[row];
                b.svco = AV_SVCO[row];
                b.sbs  = AV_SBS[row];
                b.gc3  = AV_GC3[row];
            end
            MODE_DVBT:
            begin
                b.spd  = DV_SPD[row];
                b.svco = DV_SVCO[row];
                b.sbs  = DV_SBS[row];
                b.gc3  = DV_GC3[row];
            end
            default:
            begin
                b.spd  = {1'b0, ORIG_SPD[row]};
                b.sbs  = {1'b0, ORIG_BS[row]};
                b.bp   = ORIG_BP[row];
                b.gc3  = ORIG_GC3[row];
                b.d15  = ORIG_D15[row];
            end
        endcase
        return b;
    endfunction

    // Channel register byte k of a run
    function automatic logic [BYTE_W-1:0] tpwp_byte(input tpwp_mode_t mode,
                                                    input logic lpf,
                                                    input tpwp_band_t b,
                                                    input logic [N_W-1:0] n,
                                                    input logic [IDX_W-1:0] k);
        logic [BYTE_W-1:0] v;
        logic              dvb;
        dvb = (mode == MODE_DVBT);
        case (k)
            4'd0: v = {2'b00, n[11:6]};
            4'd1: v = {n[5:0], 2'b00};
            default: v = 8'h00;
        endcase
        if (mode == MODE_ORIG)
        begin
            case (k)
                4'd2: v = 8'h40;
                4'd3: v = lpf ? 8'h72 : 8'h52;
                4'd4: v = {b.spd[1:0], b.d15, b.sbs[1:0], b.bp};
                4'd5: v = 8'h8F | {2'b00, b.gc3, 4'h0};
                4'd6: v = 8'h8F;
                default: ;
            endcase
        end
        else
        begin
            case (k)
                4'd2:  v = 8'h00;
                4'd3:  v = 8'h16;
                4'd4:  v = {b.spd, b.svco, b.sbs};
                4'd5:  v = (dvb ? 8'h40 : 8'h80) | {2'b00, b.gc3, 4'h0} | 8'h0B;
                4'd6:  v = 8'h0C;
                4'd7:  v = dvb ? 8'h06 : 8'h04;
                4'd8:  v = dvb ? 8'h24 : 8'h20;
                4'd9:  v = 8'hFF;
                4'd10: v = dvb ? 8'h60 : 8'hE0;
                4'd11: v = 8'h00;
                4'd12: v = lpf ? 8'h3B : 8'h39;
                default: ;
            endcase
        end
        return v;
    endfunction

endpackage

// ===== sv/tuner_pll_word_programmer_core.sv =====
// Top level of the tuner PLL word programmer: mode register, front, queue, back.
// Depends on tpwp_pkg, tpwp_front, tpwp_queue and tpwp_back.
`timescale 1ns / 1ps

// Each request (RF frequency in Hz plus a video standard index) yields one run of
// channel register bytes, one byte per output transfer: 7 bytes when tuner_mode is 0
// (or the unused code 3), 13 bytes in either A-variant mode (1 analog, 2 DVB-T).
// byte_index counts from the first divider register and last_byte marks the end of
// the run. The byte emitter sends one byte per cycle while out_stall is low and
// sets the sustained rate. On its way to the first byte a request passes the
// input register and band search, the queue, the rounding shift, the reciprocal
// multiply, the emitter and the output register. A two-entry queue
// sits between the band search and the divider pipeline, so new requests keep
// being taken while an earlier run is still going out. Divider is
// round(2^spd * f_lo / 250000) with halves rounded up; only its low 12 bits are
// used. tuner_mode sits at APB address 0 (bits 1:0), resets to 0 and should be
// written only while no run is pending.
module tuner_pll_word_programmer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tpwp_pkg::RF_W-1:0]   rf_frequency_hz,
    input  logic [tpwp_pkg::SI_W-1:0]   standard_index,
    // Byte channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tpwp_pkg::IDX_W-1:0]  byte_index,
    output logic [tpwp_pkg::BYTE_W-1:0] byte_value,
    output logic                        last_byte
);
    import tpwp_pkg::*;

    logic [1:0] tuner_mode_reg, tuner_mode_next;
    logic       cfg_wr;
    logic       push, pop, q_full, head_valid;
    tpwp_job_t  push_job, head_job;

    // Register decode on paddr[2]: only register 0 exists
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, tuner_mode_reg} : 32'd0;

    assign tuner_mode_next = cfg_wr ? pwdata[1:0] : tuner_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tuner_mode_reg <= TM_ORIG;
        else
            tuner_mode_reg <= tuner_mode_next;
    end

    tpwp_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rf_frequency_hz (rf_frequency_hz),
        .standard_index  (standard_index),
        .tuner_mode      (tuner_mode_reg),
        .push            (push),
        .push_job        (push_job),
        .q_full          (q_full)
    );

    tpwp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    tpwp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_index (byte_index),
        .byte_value (byte_value),
        .last_byte  (last_byte)
    );

    // Runs end only at position 6 or 12
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> (byte_index == LAST_ORIG || byte_index == LAST_A))
        else $error("last byte at wrong position");

    // Inside a run bytes go out back to back with consecutive indexes
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_byte |=>
            out_valid && byte_index == $past(byte_index) + 4'd1)
        else $error("gap or skip inside a byte run");

    // Output only drains after the final byte of a run
    a_drain_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(last_byte))
        else $error("output went idle mid-run");

    // The queue is never pushed while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("job queue overflow");

endmodule

// ===== sv/tpwp_front.sv =====
// Front end: takes requests, forms the LO frequency and picks the band row.
// Depends on tpwp_pkg; pushes classified jobs into tpwp_queue.
`timescale 1ns / 1ps

module tpwp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [tpwp_pkg::RF_W-1:0] rf_frequency_hz,
    input  logic [tpwp_pkg::SI_W-1:0] standard_index,
    input  logic [1:0]                tuner_mode,
    output logic                      push,
    output tpwp_pkg::tpwp_job_t       push_job,
    input  logic                      q_full
);
    import tpwp_pkg::*;

    logic             valid_reg, valid_next;
    logic [F_W-1:0]   f_lo_reg;
    logic             lpf_reg;
    logic [SI_W-1:0]  si;
    logic             accept;
    tpwp_mode_t       mode;

    // Clamp the standard to the usable rows
    always_comb
    begin
        si = standard_index;
        if ({1'b0, standard_index} >= (SI_W + 1)'(STD_LIMIT))
            si = SI_W'(STD_LIMIT - 1);
    end

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_lo_reg <= F_W'(rf_frequency_hz) + F_W'(STD_IF_HZ[si]);
            lpf_reg  <= STD_LPF[si];
        end
    end

    always_comb
    begin
        case (tuner_mode)
            TM_ANALOG: mode = MODE_ANALOG;
            TM_DVBT:   mode = MODE_DVBT;
            default:   mode = MODE_ORIG;
        endcase
    end

    always_comb
    begin
        push_job.f_lo = f_lo_reg;
        push_job.mode = mode;
        push_job.row  = tpwp_find_row(mode, f_lo_reg);
        push_job.lpf  = lpf_reg;
    end

endmodule

// ===== sv/tpwp_queue.sv =====
// Two-entry job queue between front and back.
// Depends on tpwp_pkg for the job type.
`timescale 1ns / 1ps

module tpwp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tpwp_pkg::tpwp_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output tpwp_pkg::tpwp_job_t head_job
);
    import tpwp_pkg::*;

    tpwp_job_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== sv/tpwp_back.sv =====
// Back end: divider pipeline (shift/round, reciprocal multiply) and byte emitter.
// Depends on tpwp_pkg; pops jobs from tpwp_queue.
`timescale 1ns / 1ps

module tpwp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  tpwp_pkg::tpwp_job_t         head_job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tpwp_pkg::IDX_W-1:0]  byte_index,
    output logic [tpwp_pkg::BYTE_W-1:0] byte_value,
    output logic                        last_byte
);
    import tpwp_pkg::*;

    // Stage A: scaled, rounded, pre-shifted numerator
    logic              a_valid_reg, a_valid_next;
    tpwp_job_t         a_job_reg;
    logic [Y_W-1:0]    a_y_reg;
    // Stage B: divider word
    logic              b_valid_reg, b_valid_next;
    tpwp_job_t         b_job_reg;
    logic [N_W-1:0]    b_n_reg;
    // Emitter
    logic              e_valid_reg, e_valid_next;
    tpwp_job_t         e_job_reg;
    logic [N_W-1:0]    e_n_reg;
    logic [IDX_W-1:0]  e_cnt_reg, e_cnt_next;
    // Output register
    logic              o_valid_reg, o_valid_next;
    logic [IDX_W-1:0]  o_idx_reg;
    logic [BYTE_W-1:0] o_val_reg;
    logic              o_last_reg;

    tpwp_band_t        head_band;
    logic [X_W-1:0]    x;
    logic [PROD_W-1:0] prod;
    logic              out_load, e_last, e_free, b_move, a_move;

    assign head_band = tpwp_band(head_job.mode, head_job.row);
    assign x = (X_W'(head_job.f_lo) << head_band.spd) + X_W'(ROUND_HALF);
    assign prod = PROD_W'(a_y_reg) * PROD_W'(RECIP);

    assign out_load = e_valid_reg && (!o_valid_reg || !out_stall);
    assign e_last   = (e_cnt_reg == ((e_job_reg.mode == MODE_ORIG) ? LAST_ORIG : LAST_A));
    assign e_free   = !e_valid_reg || (out_load && e_last);
    assign b_move   = b_valid_reg && e_free;
    assign a_move   = a_valid_reg && (!b_valid_reg || b_move);
    assign pop      = head_valid && (!a_valid_reg || a_move);

    always_comb
    begin
        a_valid_next = pop ? 1'b1 : (a_move ? 1'b0 : a_valid_reg);
        b_valid_next = a_move ? 1'b1 : (b_move ? 1'b0 : b_valid_reg);
        e_valid_next = b_move ? 1'b1 : ((out_load && e_last) ? 1'b0 : e_valid_reg);
        e_cnt_next   = e_cnt_reg;
        if (b_move)
            e_cnt_next = '0;
        else if (out_load)
            e_cnt_next = e_cnt_reg + 4'd1;
        o_valid_next = out_load ? 1'b1 : ((o_valid_reg && !out_stall) ? 1'b0 : o_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            e_cnt_reg   <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            e_valid_reg <= e_valid_next;
            e_cnt_reg   <= e_cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_job_reg <= head_job;
            a_y_reg   <= x[X_W-1:PRE_SHIFT];
        end
        if (a_move)
        begin
            b_job_reg <= a_job_reg;
            b_n_reg   <= prod[RECIP_SHIFT + N_W - 1:RECIP_SHIFT];
        end
        if (b_move)
        begin
            e_job_reg <= b_job_reg;
            e_n_reg   <= b_n_reg;
        end
        if (out_load)
        begin
            o_idx_reg  <= e_cnt_reg;
            o_val_reg  <= tpwp_byte(e_job_reg.mode, e_job_reg.lpf,
                                    tpwp_band(e_job_reg.mode, e_job_reg.row),
                                    e_n_reg, e_cnt_reg);
            o_last_reg <= e_last;
        end
    end

    assign out_valid  = o_valid_reg;
    assign byte_index = o_idx_reg;
    assign byte_value = o_val_reg;
    assign last_byte  = o_last_reg;

endmodule
